>>> hw/rtl/mhw_pkg.sv
// Package with the constants, types and helper functions of the mixing hash block.
`default_nettype none

package mhw_pkg;

  localparam int unsigned RotA = 39;
  localparam int unsigned RotB = 23;

  localparam logic [63:0] MulH   = 64'd5451474691133734519;
  localparam logic [63:0] AddH   = 64'd14642105499382583659;
  localparam logic [63:0] MulW   = 64'd12494398421538346499;
  localparam logic [63:0] AddW   = 64'd11411494365777922193;
  localparam logic [63:0] MulOut = 64'd14028973624453214561;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned AddrW = 4;

  typedef struct packed {
    logic [63:0] word;
    logic        first;
    logic        skip;
  } mhw_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mhw_q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_SUM1,
    ST_MUL2,
    ST_FIN
  } mhw_state_e;

  function automatic logic [63:0] rotl_a(input logic [63:0] x);
    rotl_a = (x << RotA) | (x >> (64 - RotA));
  endfunction

  function automatic logic [63:0] rotl_b(input logic [63:0] x);
    rotl_b = (x << RotB) | (x >> (64 - RotB));
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mhw_if.sv
// Stream interfaces for the word input and the hash output channels.
`default_nettype none

interface mhw_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        first;

  modport source (output valid, output data_word, output byte_count, output first,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input first,
                output ready);
endinterface

interface mhw_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mix_hash_word_stream_core.sv
// Top level of the running 64-bit mixing hash over a stream of words.
//
// Words arrive as beats on in_i (data_word, byte_count, first); bytes above
// byte_count are zeroed before absorption, a zero byte_count absorbs nothing,
// and first reloads the hash from the initial_hash register. Every input
// beat gives one output beat on out_o carrying the running hash.
// The initial_hash register sits at address 0 of the APB port. The user
// must write it only while the block is idle; the block does not enforce it.
// A beat enters a two-entry queue. The engine takes one word at a time
// through the states MUL1, SUM1, MUL2 and FIN, set by the hash feedback loop
// through the 64-bit multiplier shared by MUL1 and MUL2, and registers the
// result for out_o; a zero byte_count beat goes straight to FIN.
// Reset clears the running hash, initial_hash and the queue.
// When the receiver stalls, the finished beat is held in the output register
// while the engine works on the next word and the queue keeps accepting beats
// until it fills.
`default_nettype none

module mix_hash_word_stream_core
  import mhw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  mhw_in_if.sink           in_i,
  mhw_out_if.source        out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0]   init_q;
  logic          push, pop;
  mhw_entry_t    push_entry, pop_entry;
  mhw_q_status_t q_status;
  logic          cfg_wr;
  logic          sel_init;

  assign sel_init = (paddr[AddrW-1:3] == '0);
  assign cfg_wr   = psel && penable && pwrite && sel_init;
  assign pready   = 1'b1;
  assign prdata   = sel_init ? init_q : 64'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (cfg_wr) begin
      init_q <= pwdata;
    end
  end

  mhw_front u_front (
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  mhw_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (q_status)
  );

  mhw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_hash_i (init_q),
    .q_status_i  (q_status),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("queue written while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue read while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (init_q == $past(pwdata)))
    else $error("initial hash register not updated by write");

endmodule

`default_nettype wire

>>> hw/rtl/mhw_front.sv
// Front end: accepts word beats, masks the unused bytes and flags empty words.
`default_nettype none

module mhw_front
  import mhw_pkg::*;
(
  mhw_in_if.sink        in_i,
  input  mhw_q_status_t q_status_i,
  output logic          push_o,
  output mhw_entry_t    entry_o
);

  logic [63:0] masked;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (4'(i) < in_i.byte_count) ? in_i.data_word[8*i +: 8] : 8'h00;
    end
  end

  assign in_i.ready    = !q_status_i.full;
  assign push_o        = in_i.valid && !q_status_i.full;
  assign entry_o.word  = masked;
  assign entry_o.first = in_i.first;
  assign entry_o.skip  = (in_i.byte_count == 4'd0);

endmodule

`default_nettype wire

>>> hw/rtl/mhw_fifo.sv
// Short queue of classified words between the front end and the hash engine.
`default_nettype none

module mhw_fifo
  import mhw_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mhw_entry_t    entry_i,
  input  logic          pop_i,
  output mhw_entry_t    entry_o,
  output mhw_q_status_t status_o
);

  mhw_entry_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, wptr_d;
  logic [QueuePtrW-1:0] rptr_q, rptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  function automatic logic [QueuePtrW-1:0] next_ptr(input logic [QueuePtrW-1:0] p);
    next_ptr = (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
  endfunction

  always_comb begin
    wptr_d = push_i ? next_ptr(wptr_q) : wptr_q;
    rptr_d = pop_i ? next_ptr(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  assign entry_o        = mem_q[rptr_q];
  assign status_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

>>> hw/rtl/mhw_back.sv
// Hash engine: absorbs queued words through a shared 64-bit multiplier in four steps.
`default_nettype none

module mhw_back
  import mhw_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [63:0]   init_hash_i,
  input  mhw_q_status_t q_status_i,
  input  mhw_entry_t    entry_i,
  output logic          pop_o,
  mhw_out_if.source     out_o
);

  mhw_state_e  state_q, state_d;
  logic [63:0] running_q, running_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q, hash_d;

  logic [63:0] h_q, w_q, t_q, x_q;
  logic        skip_q;
  logic [63:0] pa_ll_q, pb_ll_q;
  logic [31:0] pa_x_q, pb_x_q;

  logic [63:0] mop, mk;
  logic [63:0] new_hash;
  logic [63:0] t_d;
  logic        out_free, done, load;

  always_comb begin
    mop      = (state_q == ST_MUL1) ? h_q : t_q;
    mk       = (state_q == ST_MUL1) ? MulH : MulOut;
    new_hash = skip_q ? h_q : (pa_ll_q + {pa_x_q, 32'h0});
    t_d      = (pa_ll_q + {pa_x_q, 32'h0} + AddH) ^ (pb_ll_q + {pb_x_q, 32'h0} + AddW) ^ x_q;
    out_free = !out_valid_q || out_o.ready;
    done     = (state_q == ST_FIN) && out_free;
    load     = !q_status_i.empty && ((state_q == ST_IDLE) || done);
    pop_o    = load;

    state_d     = state_q;
    running_d   = done ? new_hash : running_q;
    out_valid_d = out_valid_q && !out_o.ready;
    hash_d      = hash_q;
    if (done) begin
      out_valid_d = 1'b1;
      hash_d      = new_hash;
    end

    case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = entry_i.skip ? ST_FIN : ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_SUM1;
      ST_SUM1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_FIN;
      ST_FIN: begin
        if (load) begin
          state_d = entry_i.skip ? ST_FIN : ST_MUL1;
        end else if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    if (load) begin
      h_q    <= entry_i.first ? init_hash_i : running_d;
      w_q    <= entry_i.word;
      skip_q <= entry_i.skip;
    end
    if ((state_q == ST_MUL1) || (state_q == ST_MUL2)) begin
      pa_ll_q <= 64'(mop[31:0]) * 64'(mk[31:0]);
      pa_x_q  <= 32'(mop[31:0] * mk[63:32]) + 32'(mop[63:32] * mk[31:0]);
    end
    if (state_q == ST_MUL1) begin
      pb_ll_q <= 64'(w_q[31:0]) * 64'(MulW[31:0]);
      pb_x_q  <= 32'(w_q[31:0] * MulW[63:32]) + 32'(w_q[63:32] * MulW[31:0]);
      x_q     <= rotl_a(h_q + w_q) ^ rotl_b(h_q - w_q);
    end
    if (state_q == ST_SUM1) begin
      t_q <= t_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.hash_value = hash_q;

endmodule

`default_nettype wire
